[src/upd_pkg.sv]
// Shared types and constants of the URI percent decoder.
// No dependencies; every other file of the block imports this package.
package upd_pkg;

  localparam int unsigned UPD_QUEUE_DEPTH = 4;  // groups buffered between parser and serialiser
  localparam int unsigned UPD_MAX_RUN     = 4;  // bytes one input can produce

  localparam logic [7:0] UPD_CHAR_PCT = 8'h25;  // '%'

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_final;
  } upd_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_run_end;
    logic       out_string_end;
    logic       out_malformed;
  } upd_out_t;

  // All bytes produced by one input transaction, emitted oldest first.
  typedef struct packed {
    logic [UPD_MAX_RUN-1:0][7:0]     data;
    logic [$clog2(UPD_MAX_RUN)-1:0]  last_idx;
    logic                            str_end;
    logic                            malformed;
  } upd_grp_t;

endpackage

[src/uri_percent_decoder.sv]
// Top level of the URI percent decoder: parser, group queue and serialiser.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Usage:
//   Input is a queue write port: one encoded character per transaction
//   (push high, full low), in_final marking the last character of a string.
//   Results are read like a queue: while out_empty is low the oldest decoded
//   byte is on out_data, and out_pop takes it.
//   Each input yields 0 to 4 result bytes; the last one of a run carries
//   out_run_end, the last of a string out_string_end. A malformed string gives
//   a single zero byte with out_malformed, out_run_end and out_string_end set.
// Timing:
//   An input is taken every cycle while the group queue has room; its bytes
//   pass through the queue and the output group register to the result port.
//   It moves one byte per cycle while out_pop is high, so multi-byte escapes
//   are absorbed by the queue (QUEUE_DEPTH groups) plus the output group.
// Reset (rst_n low, synchronous) empties the queue and output and returns the
//   parser to the literal state. If the receiver stops popping, the queue fills
//   and full rises; nothing is dropped.
module uri_percent_decoder import upd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = UPD_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  upd_in_t  in_data,
  input  logic     out_pop,
  output logic     out_empty,
  output upd_out_t out_data
);

  logic     fire;
  logic     f_push;
  upd_grp_t f_grp;
  logic     q_pop, q_empty;
  upd_grp_t q_grp;

  assign fire = in_push && !in_full;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_data  (in_data),
    .grp_push (f_push),
    .grp      (f_grp)
  );

  upd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_grp),
    .full      (in_full),
    .pop       (q_pop),
    .pop_data  (q_grp),
    .empty     (q_empty)
  );

  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (q_grp),
    .grp_valid (!q_empty),
    .grp_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_malformed_ends: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.out_malformed |->
      out_data.out_string_end && out_data.out_run_end && out_data.out_char == 8'h00)
    else $error("malformed result not a lone terminating zero byte");

  a_string_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.out_string_end |-> out_data.out_run_end)
    else $error("string end without run end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("block not empty after reset");

  a_full_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !q_pop |=> in_full)
    else $error("queue full flag dropped without a pop");
`endif

endmodule

[src/upd_front.sv]
// Parser: takes one encoded character per cycle while fire is high and builds the
// group of output bytes it causes. Depends on upd_pkg.
module upd_front import upd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  upd_in_t  in_data,
  output logic     grp_push,
  output upd_grp_t grp
);

  typedef enum logic [2:0] {
    PH_LITERAL,
    PH_LEAD_HI,
    PH_LEAD_LO,
    PH_CONT_PCT,
    PH_CONT_HI,
    PH_CONT_LO
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [7:0]  seq_r [0:2];
  logic [7:0]  seq_nxt [0:2];
  logic [1:0]  cont_r, cont_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        err_r, err_nxt;

  logic [2:0]  n_res;
  logic [4:0]  hex;
  logic [7:0]  b;

  // {valid, value}
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h3B, 8'h2C, 8'h2F, 8'h3F, 8'h3A, 8'h40,
      8'h26, 8'h3D, 8'h2B, 8'h24, 8'h23: r = 1'b1;
      default:                           r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    hi_nxt    = hi_r;
    seq_nxt   = seq_r;
    cont_nxt  = cont_r;
    held_nxt  = held_r;
    err_nxt   = err_r;
    n_res     = '0;
    grp       = '0;
    hex       = hex_dec(in_data.in_char);
    b         = {hi_r, hex[3:0]};

    if (!err_r) begin
      unique case (phase_r)
        PH_LEAD_HI: begin
          if (!hex[4]) err_nxt = 1'b1;
          else begin
            hi_nxt    = hex[3:0];
            first_nxt = in_data.in_char;
            phase_nxt = PH_LEAD_LO;
          end
        end
        PH_LEAD_LO: begin
          if (!hex[4]) err_nxt = 1'b1;
          else if (!b[7]) begin
            if (is_reserved(b)) begin
              // reserved characters stay escaped, hex case as received
              grp.data[0] = UPD_CHAR_PCT;
              grp.data[1] = first_r;
              grp.data[2] = in_data.in_char;
              n_res       = 3'd3;
            end else begin
              grp.data[0] = b;
              n_res       = 3'd1;
            end
            phase_nxt = PH_LITERAL;
          end else begin
            if (b[7:5] == 3'b110)        cont_nxt = 2'd1;
            else if (b[7:4] == 4'b1110)  cont_nxt = 2'd2;
            else if (b[7:3] == 5'b11110) cont_nxt = 2'd3;
            else                         err_nxt  = 1'b1;
            if (!err_nxt) begin
              seq_nxt[0] = b;
              held_nxt   = 2'd1;
              phase_nxt  = PH_CONT_PCT;
            end
          end
        end
        PH_CONT_PCT: begin
          if (in_data.in_char != UPD_CHAR_PCT) err_nxt = 1'b1;
          else phase_nxt = PH_CONT_HI;
        end
        PH_CONT_HI: begin
          if (!hex[4]) err_nxt = 1'b1;
          else begin
            hi_nxt    = hex[3:0];
            phase_nxt = PH_CONT_LO;
          end
        end
        PH_CONT_LO: begin
          if (!hex[4] || b[7:6] != 2'b10) err_nxt = 1'b1;
          else if (cont_r == 2'd1) begin
            // sequence complete: held bytes then this one
            for (int k = 0; k < UPD_MAX_RUN; k++) begin
              if (k < 3 && 2'(k) < held_r) grp.data[k] = seq_r[k];
              else if (2'(k) == held_r)    grp.data[k] = b;
            end
            n_res     = {1'b0, held_r} + 3'd1;
            held_nxt  = '0;
            cont_nxt  = '0;
            phase_nxt = PH_LITERAL;
          end else begin
            seq_nxt[held_r] = b;
            held_nxt        = held_r + 2'd1;
            cont_nxt        = cont_r - 2'd1;
            phase_nxt       = PH_CONT_PCT;
          end
        end
        default: begin
          if (in_data.in_char == UPD_CHAR_PCT) phase_nxt = PH_LEAD_HI;
          else begin
            grp.data[0] = in_data.in_char;
            n_res       = 3'd1;
          end
        end
      endcase
    end

    if (in_data.in_final) begin
      if (err_nxt || phase_nxt != PH_LITERAL) begin
        grp.data      = '0;
        grp.malformed = 1'b1;
        n_res         = 3'd1;
      end
      grp.str_end = 1'b1;
      phase_nxt   = PH_LITERAL;
      first_nxt   = '0;
      hi_nxt      = '0;
      cont_nxt    = '0;
      held_nxt    = '0;
      err_nxt     = 1'b0;
    end else if (err_nxt) begin
      n_res = '0;
    end

    grp.last_idx = 2'(n_res - 3'd1);
    grp_push     = fire && (n_res != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LITERAL;
      first_r <= '0;
      hi_r    <= '0;
      cont_r  <= '0;
      held_r  <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      hi_r    <= hi_nxt;
      cont_r  <= cont_nxt;
      held_r  <= held_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) seq_r <= seq_nxt;
  end

endmodule

[src/upd_queue.sv]
// Short queue of byte groups between parser and serialiser.
// Depends on upd_pkg.
module upd_queue import upd_pkg::*; #(
  parameter int unsigned DEPTH = UPD_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  upd_grp_t push_data,
  output logic     full,
  input  logic     pop,
  output upd_grp_t pop_data,
  output logic     empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  upd_grp_t        mem_r [0:DEPTH-1];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (do_pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

[src/upd_back.sv]
// Serialiser: unpacks the head group one byte per transaction onto the result port.
// Depends on upd_pkg.
module upd_back import upd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  upd_grp_t grp,
  input  logic     grp_valid,
  output logic     grp_pop,
  input  logic     out_pop,
  output logic     out_empty,
  output upd_out_t out_data
);

  localparam int unsigned IW = $clog2(UPD_MAX_RUN);

  upd_grp_t       cur_r;
  logic           vld_r;
  logic [IW-1:0]  idx_r;
  logic           last, take, done;

  assign last    = (idx_r == cur_r.last_idx);
  assign take    = vld_r && out_pop;
  assign done    = take && last;
  assign grp_pop = grp_valid && (!vld_r || done);

  assign out_empty               = !vld_r;
  assign out_data.out_char       = cur_r.data[idx_r];
  assign out_data.out_run_end    = last;
  assign out_data.out_string_end = last && cur_r.str_end;
  assign out_data.out_malformed  = cur_r.malformed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (grp_pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (done) begin
      vld_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (grp_pop) cur_r <= grp;
  end

endmodule

[verif/testbench.sv]
// Self-checking testbench for uri_percent_decoder: directed and random encoded strings,
// with an in-line prediction of every decoded byte and its end/error flags.
// Depends on upd_pkg and the uri_percent_decoder RTL.
module testbench import upd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_CHARS = 160;
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    PH_TEXT,
    PH_LEAD_HI,
    PH_LEAD_LO,
    PH_CONT_PCT,
    PH_CONT_HI,
    PH_CONT_LO
  } parse_phase_t;

  // Tracks the decoder's parse state and holds the bytes it still owes us.
  class decoded_stream;
    parse_phase_t phase;
    logic [7:0]   lead_hex_char;
    logic [3:0]   hi_nib;
    logic [7:0]   seq_buf [4];
    logic [1:0]   conts_left;
    logic [2:0]   held;
    logic         failed;
    upd_out_t     bytes_due [$];
    int unsigned  mismatches;
    int unsigned  bytes_matched;
    int unsigned  bad_strings;

    function new();
      clear_state();
      mismatches    = 0;
      bytes_matched = 0;
      bad_strings   = 0;
    endfunction

    function void clear_state();
      phase         = PH_TEXT;
      lead_hex_char = 8'h00;
      hi_nib        = 4'h0;
      conts_left    = 2'd0;
      held          = 3'd0;
      failed        = 1'b0;
    endfunction

    function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= "0" && c <= "9") v = 4'(c - 8'h30);
      else if (c >= "a" && c <= "f") v = 4'(c - 8'h57);
      else if (c >= "A" && c <= "F") v = 4'(c - 8'h37);
      else return 1'b0;
      return 1'b1;
    endfunction

    function bit reserved_char(input logic [7:0] b);
      return b inside {";", ",", "/", "?", ":", "@", "&", "=", "+", "$", "#"};
    endfunction

    function void consume_char(input upd_in_t item);
      logic [7:0] run [$];
      logic [7:0] c;
      logic [7:0] b;
      logic [3:0] v;
      logic [1:0] k;
      bit         err;
      upd_out_t   r;
      c   = item.in_char;
      err = 1'b0;
      k   = 2'd0;
      if (!failed) begin
        case (phase)
          PH_LEAD_HI: begin
            if (!hex_digit(c, v)) err = 1'b1;
            else begin
              hi_nib        = v;
              lead_hex_char = c;
              phase         = PH_LEAD_LO;
            end
          end
          PH_LEAD_LO: begin
            if (!hex_digit(c, v)) err = 1'b1;
            else begin
              b = {hi_nib, v};
              if (!b[7]) begin
                // reserved characters stay escaped, original hex case kept
                if (reserved_char(b)) begin
                  run.push_back(UPD_CHAR_PCT);
                  run.push_back(lead_hex_char);
                  run.push_back(c);
                end else begin
                  run.push_back(b);
                end
                phase = PH_TEXT;
              end else begin
                if (b[7:5] == 3'b110) k = 2'd1;
                else if (b[7:4] == 4'b1110) k = 2'd2;
                else if (b[7:3] == 5'b11110) k = 2'd3;
                else err = 1'b1;
                if (!err) begin
                  seq_buf[0] = b;
                  held       = 3'd1;
                  conts_left = k;
                  phase      = PH_CONT_PCT;
                end
              end
            end
          end
          PH_CONT_PCT: begin
            if (c != UPD_CHAR_PCT) err = 1'b1;
            else phase = PH_CONT_HI;
          end
          PH_CONT_HI: begin
            if (!hex_digit(c, v)) err = 1'b1;
            else begin
              hi_nib = v;
              phase  = PH_CONT_LO;
            end
          end
          PH_CONT_LO: begin
            if (!hex_digit(c, v)) err = 1'b1;
            else begin
              b = {hi_nib, v};
              if (b[7:6] != 2'b10) err = 1'b1;
              else begin
                seq_buf[held[1:0]] = b;
                held       = held + 3'd1;
                conts_left = conts_left - 2'd1;
                if (conts_left == 2'd0) begin
                  for (int i = 0; i < held; i++) run.push_back(seq_buf[i]);
                  held  = 3'd0;
                  phase = PH_TEXT;
                end else begin
                  phase = PH_CONT_PCT;
                end
              end
            end
          end
          default: begin
            if (c == UPD_CHAR_PCT) phase = PH_LEAD_HI;
            else run.push_back(c);
          end
        endcase
      end
      if (err) failed = 1'b1;

      if (item.in_final) begin
        // a string that stops inside an escape or sequence is malformed
        if (!failed && phase != PH_TEXT) failed = 1'b1;
        if (failed) begin
          run.delete();
          run.push_back(8'h00);
        end
      end else if (failed) begin
        run.delete();
      end

      foreach (run[i]) begin
        r.out_char       = run[i];
        r.out_run_end    = (i == run.size() - 1);
        r.out_string_end = item.in_final && (i == run.size() - 1);
        r.out_malformed  = item.in_final && failed;
        bytes_due.push_back(r);
      end
      if (item.in_final) begin
        if (failed) bad_strings++;
        clear_state();
      end
    endfunction

    function void match_byte(input upd_out_t got);
      upd_out_t want;
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected byte %02h (run_end %0b str_end %0b malformed %0b)",
                   $time, got.out_char, got.out_run_end, got.out_string_end,
                   got.out_malformed);
        return;
      end
      want = bytes_due.pop_front();
      if (got.out_char !== want.out_char || got.out_run_end !== want.out_run_end ||
          got.out_string_end !== want.out_string_end ||
          got.out_malformed !== want.out_malformed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b", $time,
                   want.out_char, want.out_run_end, want.out_string_end, want.out_malformed,
                   got.out_char, got.out_run_end, got.out_string_end, got.out_malformed);
      end else begin
        bytes_matched++;
      end
    endfunction
  endclass

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  upd_in_t  in_data = '0;
  logic     out_pop = 1'b0;
  logic     out_empty;
  upd_out_t out_data;

  decoded_stream stream;
  logic [7:0]    text [$];
  bit            calm;
  int unsigned   chars_sent;
  int unsigned   strings_sent;
  int unsigned   quiet_cycles = 0;

  uri_percent_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Both channels observed at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) stream.consume_char(in_data);
      if (out_pop && !out_empty) stream.match_byte(out_data);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= calm || ($urandom_range(99) >= 25);
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  function automatic void add_escape(input logic [7:0] b);
    text.push_back(UPD_CHAR_PCT);
    text.push_back(hex_char(b[7:4]));
    text.push_back(hex_char(b[3:0]));
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  // Mostly well-formed strings; about one in five gets a byte overwritten or is cut short.
  function automatic void build_string();
    logic [7:0] b;
    int         len;
    int         cut;
    int unsigned tokens;
    tokens = $urandom_range(6, 1);
    repeat (tokens) begin
      case ($urandom_range(2))
        0: begin
          do b = 8'($urandom_range(255)); while (b == UPD_CHAR_PCT);
          text.push_back(b);
        end
        1: begin
          if ($urandom_range(1)) begin
            do b = 8'($urandom_range(64, 32)); while (!stream.reserved_char(b));
          end else begin
            b = 8'($urandom_range(127));
          end
          add_escape(b);
        end
        default: begin
          len = $urandom_range(4, 2);
          case (len)
            2:       add_escape({3'b110, 5'($urandom)});
            3:       add_escape({4'b1110, 4'($urandom)});
            default: add_escape({5'b11110, 3'($urandom)});
          endcase
          repeat (len - 1) add_escape({2'b10, 6'($urandom)});
        end
      endcase
    end
    case ($urandom_range(19))
      0, 1: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      2: text[$urandom_range(text.size() - 1)] = UPD_CHAR_PCT;
      3: begin
        cut  = $urandom_range(text.size() - 1);
        text = text[0:cut];
      end
      default: ;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c, input logic fin);
    while (!calm && $urandom_range(99) < 25) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push         <= 1'b1;
    in_data.in_char  <= c;
    in_data.in_final <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    strings_sent++;
    text.delete();
  endtask

  initial begin
    int unsigned directed_chars;
    stream       = new();
    calm         = 1'b0;
    chars_sent   = 0;
    strings_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, reserved echo, two-byte sequence
    text.push_back(8'h00);
    add_text("%2F%c3%a9");
    text.push_back(8'hFF);
    send_string();
    add_text("%80");       // continuation class as lead
    send_string();
    add_text("%F8");       // 11111xxx lead
    send_string();
    add_text("%G");        // bad hex digit
    send_string();
    add_text("%e2x");      // continuation without its '%'
    send_string();
    add_text("%C3%41");    // continuation byte of the wrong class
    send_string();
    add_text("%");         // string ends inside an escape
    send_string();

    directed_chars = chars_sent;
    while (chars_sent < directed_chars + RANDOM_CHARS) begin
      calm = (chars_sent >= directed_chars + 60) && (chars_sent < directed_chars + 110);
      build_string();
      send_string();
    end
    calm    = 1'b0;
    in_push <= 1'b0;

    while (stream.bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d strings (%0d characters); %0d decoded bytes checked, %0d strings flagged",
             strings_sent, chars_sent, stream.bytes_matched, stream.bad_strings);
    $display("malformed; %0d mismatches.", stream.mismatches);
    if (stream.mismatches == 0 && stream.bytes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
